[rtl/dda_pkg.sv]
// ----------------------------------------------------------------------------
// dda_pkg
// Shared types, constants and helpers of the DDA line rasterizer.
// ----------------------------------------------------------------------------
package dda_pkg;

   localparam int MAX_DIM         = 64;
   localparam int COORD_FRAC_BITS = 4;
   localparam int ACC_FRAC        = 16;
   localparam int COORD_W         = 12;
   localparam int DIM_W           = 7;
   localparam int PIX_W           = 6;
   localparam int COLOR_W         = 24;
   localparam int SLOPE_W         = ACC_FRAC + 2;
   localparam int QUO_W           = ACC_FRAC + 1;
   localparam int DVD_W           = COORD_W + ACC_FRAC;
   localparam int DIV_CNT_W       = $clog2(DVD_W);
   localparam int OFF_W           = COORD_FRAC_BITS + 1;
   localparam int PROD_W          = OFF_W + SLOPE_W;
   localparam int ACC_W           = 28;
   localparam int CSR_IDX_W       = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_RASTER_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RASTER_HEIGHT = 2'd1;

   typedef struct packed {
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
      logic [COLOR_W-1:0]        line_color;
   } req_word_type;

   typedef struct packed {
      logic [PIX_W-1:0]   pixel_x;
      logic [PIX_W-1:0]   pixel_y;
      logic [COLOR_W-1:0] pixel_color;
      logic               last_pixel;
   } rsp_word_type;

   typedef struct packed {
      logic [COLOR_W-1:0]        color;
      logic signed [COORD_W-1:0] first_x;
      logic signed [COORD_W-1:0] first_y;
      logic                      steep;
      logic                      dir_down;
      logic signed [COORD_W-1:0] maj_start;
      logic signed [COORD_W-1:0] maj_end;
      logic signed [COORD_W-1:0] minor_raw;
      logic signed [OFF_W-1:0]   off;
      logic signed [SLOPE_W-1:0] slope;
      logic signed [SLOPE_W-1:0] step;
   } cmd_type;

   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
   } raster_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_DIV,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_MUL,
      B_INIT,
      B_FIRST,
      B_STEP,
      B_FLUSH
   } back_state_type;

   function automatic logic signed [COORD_W-1:0] rnd_coord(input logic signed [COORD_W-1:0] v);
      logic signed [COORD_W:0] t;
      t = {v[COORD_W-1], v} + (COORD_W+1)'(1 << (COORD_FRAC_BITS-1))
          - {{COORD_W{1'b0}}, v[COORD_W-1]};
      return COORD_W'(t >>> COORD_FRAC_BITS);
   endfunction

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] r);
      return (r > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r;
   endfunction

endpackage

[rtl/dda_line_rasterizer.sv]
// ----------------------------------------------------------------------------
// dda_line_rasterizer
// DDA line rasterizer: one line word in, one pixel word per raster pixel out.
// ----------------------------------------------------------------------------
// In the front part the slope comes from a restoring divider at one
// quotient bit per cycle (28 steps); in the back part the stepper walks
// the rounded span of the major axis (at most 256 within the coordinate
// range) and makes one pixel a cycle while the output is not stalled. The
// two parts overlap through a two-entry command queue, so the sustained
// time per line is set by the slower of the two. Pixels outside the raster
// are dropped; the last emitted pixel of a line carries last_pixel. The
// raster size registers are to be written while idle; the block itself
// does not enforce it.
// ----------------------------------------------------------------------------
module dda_line_rasterizer import dda_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_word_type         req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_word_type         rsp_word,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wdata
);

   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   raster_type       raster;
   logic             push_valid, q_full, pop, q_empty;
   cmd_type          push_word, head_word;

   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_RASTER_WIDTH:  width_in  = csr_wdata;
            CSR_RASTER_HEIGHT: height_in = csr_wdata;
            default: begin
            end
         endcase
      end
      raster.width  = clamp_dim(width_ff);
      raster.height = clamp_dim(height_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(MAX_DIM);
         height_ff <= DIM_W'(MAX_DIM);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   dda_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .push_valid (push_valid),
      .push_word  (push_word),
      .q_full     (q_full)
   );

   dda_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_word  (push_word),
      .q_full     (q_full),
      .pop        (pop),
      .q_empty    (q_empty),
      .head_word  (head_word)
   );

   dda_back u_back (
      .clock      (clock),
      .reset      (reset),
      .raster     (raster),
      .q_empty    (q_empty),
      .head_word  (head_word),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word)
   );

endmodule

[rtl/dda_front.sv]
// ----------------------------------------------------------------------------
// dda_front
// Accepts line words, orders endpoints, classifies shallow/steep and forms
// the rounded slope with a restoring divider, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module dda_front import dda_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         push_valid,
   output cmd_type      push_word,
   input  logic         q_full
);

   front_state_type         state_ff, state_in;
   cmd_type                 cmd_ff, cmd_in;
   logic [DVD_W-1:0]        dvd_ff, dvd_in;
   logic [COORD_W-1:0]      rem_ff, rem_in;
   logic [COORD_W-1:0]      den_ff, den_in;
   logic [QUO_W-1:0]        quo_ff, quo_in;
   logic [DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic                    neg_ff, neg_in;

   logic                    swap;
   logic signed [COORD_W-1:0] xa, ya, xb, yb;
   logic signed [COORD_W:0] dx, dy, ady;
   logic                    steep;
   logic signed [COORD_W-1:0] rxa, rya, rxb, ryb, ms, mr;
   logic signed [COORD_W+1:0] off_w;
   logic [COORD_W-1:0]      num_mag, den;
   logic [COORD_W:0]        trial;
   logic [QUO_W-1:0]        q;
   logic signed [SLOPE_W-1:0] q_s, slope;

   assign req_stall = (state_ff != F_IDLE);

   always_comb begin
      swap  = req_word.start_x > req_word.end_x;
      xa    = swap ? req_word.end_x   : req_word.start_x;
      ya    = swap ? req_word.end_y   : req_word.start_y;
      xb    = swap ? req_word.start_x : req_word.end_x;
      yb    = swap ? req_word.start_y : req_word.end_y;
      dx    = {xb[COORD_W-1], xb} - {xa[COORD_W-1], xa};
      dy    = {yb[COORD_W-1], yb} - {ya[COORD_W-1], ya};
      ady   = dy[COORD_W] ? -dy : dy;
      steep = ady > dx;
      rxa   = rnd_coord(xa);
      rya   = rnd_coord(ya);
      rxb   = rnd_coord(xb);
      ryb   = rnd_coord(yb);
      ms    = steep ? rya : rxa;
      mr    = steep ? ya : xa;
      off_w = ({{2{ms[COORD_W-1]}}, ms} <<< COORD_FRAC_BITS) - {{2{mr[COORD_W-1]}}, mr};
      num_mag = steep ? dx[COORD_W-1:0] : ady[COORD_W-1:0];
      den     = steep ? ady[COORD_W-1:0] : dx[COORD_W-1:0];

      trial = {rem_ff, dvd_ff[DVD_W-1]};
      q     = (den_ff == '0) ? '0 : quo_ff;
      q_s   = {1'b0, q};
      slope = neg_ff ? -q_s : q_s;

      push_valid = 1'b0;
      push_word  = cmd_ff;
      push_word.slope = slope;
      push_word.step  = cmd_ff.steep ? q_s : slope;

      state_in = state_ff;
      cmd_in   = cmd_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;

      case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               cmd_in.color     = req_word.line_color;
               cmd_in.first_x   = rxa;
               cmd_in.first_y   = rya;
               cmd_in.steep     = steep;
               cmd_in.dir_down  = steep & dy[COORD_W];
               cmd_in.maj_start = ms;
               cmd_in.maj_end   = steep ? ryb : rxb;
               cmd_in.minor_raw = steep ? xa : ya;
               cmd_in.off       = off_w[OFF_W-1:0];
               cmd_in.slope     = '0;
               cmd_in.step      = '0;
               dvd_in   = {num_mag, {ACC_FRAC{1'b0}}} + DVD_W'(den >> 1);
               rem_in   = '0;
               den_in   = den;
               quo_in   = '0;
               cnt_in   = '0;
               neg_in   = dy[COORD_W];
               state_in = F_DIV;
            end
         end
         F_DIV: begin
            if (trial >= {1'b0, den_ff}) begin
               rem_in = COORD_W'(trial - {1'b0, den_ff});
               quo_in = {quo_ff[QUO_W-2:0], 1'b1};
            end else begin
               rem_in = trial[COORD_W-1:0];
               quo_in = {quo_ff[QUO_W-2:0], 1'b0};
            end
            dvd_in = dvd_ff << 1;
            cnt_in = cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(DVD_W-1)) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            push_valid = 1'b1;
            if (!q_full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cmd_ff <= cmd_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

endmodule

[rtl/dda_queue.sv]
// ----------------------------------------------------------------------------
// dda_queue
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module dda_queue import dda_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  cmd_type push_word,
   output logic    q_full,
   input  logic    pop,
   output logic    q_empty,
   output cmd_type head_word
);

   cmd_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   always_comb begin
      q_full    = (count_ff == 2'd2);
      q_empty   = (count_ff == 2'd0);
      head_word = mem_ff[rd_ptr_ff];
      do_push   = push_valid & ~q_full;
      do_pop    = pop & ~q_empty;
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

[rtl/dda_back.sv]
// ----------------------------------------------------------------------------
// dda_back
// Steps the DDA along the major axis, clips each pixel to the raster and
// holds one pixel back so the final one carries the last flag.
// ----------------------------------------------------------------------------
module dda_back import dda_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  raster_type   raster,
   input  logic         q_empty,
   input  cmd_type      head_word,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   back_state_type          state_ff, state_in;
   cmd_type                 cmd_ff, cmd_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [COORD_W-1:0] pos_ff, pos_in;
   logic                    pend_valid_ff, pend_valid_in;
   rsp_word_type            pend_ff, pend_in;
   logic                    out_valid_ff, out_valid_in;
   rsp_word_type            out_ff, out_in;

   logic                    out_free;
   logic                    cand_valid;
   logic signed [COORD_W-1:0] cand_x, cand_y;
   logic                    in_raster;
   logic signed [PROD_W-1:0] pr;
   logic signed [PROD_W-COORD_FRAC_BITS-1:0] pr_sh;
   logic signed [ACC_W-1:0] acc_step, acc_rnd;
   logic signed [COORD_W-1:0] minor_pix;

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_ff;

   always_comb begin
      out_free = ~out_valid_ff | ~rsp_stall;

      pr    = prod_ff + PROD_W'(1 << (COORD_FRAC_BITS-1)) - {{(PROD_W-1){1'b0}}, prod_ff[PROD_W-1]};
      pr_sh = (PROD_W-COORD_FRAC_BITS)'(pr >>> COORD_FRAC_BITS);

      acc_step  = acc_ff + {{(ACC_W-SLOPE_W){cmd_ff.step[SLOPE_W-1]}}, cmd_ff.step};
      acc_rnd   = acc_step + ACC_W'(1 << (ACC_FRAC-1)) - {{(ACC_W-1){1'b0}}, acc_step[ACC_W-1]};
      minor_pix = COORD_W'(acc_rnd >>> ACC_FRAC);

      state_in      = state_ff;
      cmd_in        = cmd_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      pos_in        = pos_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff & rsp_stall;
      out_in        = out_ff;
      pop           = 1'b0;
      cand_valid    = 1'b0;
      cand_x        = cmd_ff.first_x;
      cand_y        = cmd_ff.first_y;

      case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               pop      = 1'b1;
               cmd_in   = head_word;
               state_in = B_MUL;
            end
         end
         B_MUL: begin
            prod_in  = cmd_ff.off * cmd_ff.slope;
            state_in = B_INIT;
         end
         B_INIT: begin
            acc_in = ({{(ACC_W-COORD_W){cmd_ff.minor_raw[COORD_W-1]}}, cmd_ff.minor_raw}
                      <<< (ACC_FRAC-COORD_FRAC_BITS))
                     + {{(ACC_W-PROD_W+COORD_FRAC_BITS){pr_sh[PROD_W-COORD_FRAC_BITS-1]}}, pr_sh};
            pos_in   = cmd_ff.maj_start;
            state_in = B_FIRST;
         end
         B_FIRST: begin
            if (out_free) begin
               cand_valid = 1'b1;
               state_in   = B_STEP;
            end
         end
         B_STEP: begin
            if (pos_ff == cmd_ff.maj_end) begin
               state_in = B_FLUSH;
            end else if (out_free) begin
               pos_in     = cmd_ff.dir_down ? pos_ff - COORD_W'(1) : pos_ff + COORD_W'(1);
               acc_in     = acc_step;
               cand_valid = 1'b1;
               cand_x     = cmd_ff.steep ? minor_pix : pos_in;
               cand_y     = cmd_ff.steep ? pos_in : minor_pix;
            end
         end
         B_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = B_IDLE;
            end else if (out_free) begin
               out_valid_in       = 1'b1;
               out_in             = pend_ff;
               out_in.last_pixel  = 1'b1;
               pend_valid_in      = 1'b0;
               state_in           = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase

      in_raster = ~cand_x[COORD_W-1] & ~cand_y[COORD_W-1]
                  & (cand_x[COORD_W-2:0] < (COORD_W-1)'(raster.width))
                  & (cand_y[COORD_W-2:0] < (COORD_W-1)'(raster.height));

      if (cand_valid && in_raster) begin
         if (pend_valid_ff) begin
            out_valid_in = 1'b1;
            out_in       = pend_ff;
         end
         pend_valid_in       = 1'b1;
         pend_in.pixel_x     = cand_x[PIX_W-1:0];
         pend_in.pixel_y     = cand_y[PIX_W-1:0];
         pend_in.pixel_color = cmd_ff.color;
         pend_in.last_pixel  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_IDLE;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      cmd_ff  <= cmd_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      pos_ff  <= pos_in;
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

endmodule

[rtl/dda_checker.sv]
// ----------------------------------------------------------------------------
// dda_checker
// Port-level checks of the DDA line rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module dda_checker import dda_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input rsp_word_type         rsp_word,
   input logic                 csr_valid,
   input logic                 csr_ready,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic [DIM_W-1:0]     csr_wdata
);

   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid && csr_ready && csr_index == CSR_RASTER_WIDTH) begin
         width_in = csr_wdata;
      end
      if (csr_valid && csr_ready && csr_index == CSR_RASTER_HEIGHT) begin
         height_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(MAX_DIM);
         height_ff <= DIM_W'(MAX_DIM);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("pixel word valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled pixel word changed");

   a_col_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> {1'b0, rsp_word.pixel_x} < clamp_dim(width_ff))
      else $error("pixel column outside raster");

   a_row_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> {1'b0, rsp_word.pixel_y} < clamp_dim(height_ff))
      else $error("pixel row outside raster");

endmodule

bind dda_line_rasterizer dda_checker u_dda_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready),
   .csr_index (csr_index),
   .csr_wdata (csr_wdata)
);

[verif/dda_line_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dda_line_checker
// Watches the line, pixel and raster register channels of the rasterizer,
// computes the pixel words each accepted line must produce and compares every
// accepted pixel word with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module dda_line_checker import dda_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  req_word_type         req_word,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  rsp_word_type         rsp_word,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wdata,
   output int                   pixels_pending,
   output int                   fail_count
);

   rsp_word_type pixel_q[$];
   logic [DIM_W-1:0] width_reg;
   logic [DIM_W-1:0] height_reg;

   function automatic longint rdiv(longint num, longint den);
      if (num >= 0) return (num + den / 2) / den;
      return -((-num + den / 2) / den);
   endfunction

   function automatic longint dim_of(logic [DIM_W-1:0] r);
      return (r > MAX_DIM) ? MAX_DIM : longint'(r);
   endfunction

   function automatic void plot(longint px, longint py, longint wd, longint ht,
                                logic [COLOR_W-1:0] color, ref int n);
      rsp_word_type p;
      if (px < 0 || px >= wd || py < 0 || py >= ht || n >= 64) return;
      p.pixel_x     = PIX_W'(px);
      p.pixel_y     = PIX_W'(py);
      p.pixel_color = color;
      p.last_pixel  = 1'b0;
      pixel_q.push_back(p);
      n++;
   endfunction

   function automatic void rasterize(req_word_type w);
      longint one, aone, scl, xa, ya, xb, yb, t, dx, dy, ady, wd, ht;
      longint slope, inv, pos, pend, off, acc, s;
      int n;
      one  = 1 << COORD_FRAC_BITS;
      aone = 1 << ACC_FRAC;
      scl  = 1 << (ACC_FRAC - COORD_FRAC_BITS);
      xa = w.start_x; ya = w.start_y; xb = w.end_x; yb = w.end_y;
      wd = dim_of(width_reg);
      ht = dim_of(height_reg);
      n = 0;
      if (xa > xb) begin
         t = xa; xa = xb; xb = t;
         t = ya; ya = yb; yb = t;
      end
      dx = xb - xa;
      dy = yb - ya;
      ady = dy < 0 ? -dy : dy;
      plot(rdiv(xa, one), rdiv(ya, one), wd, ht, w.line_color, n);
      if (ady <= dx) begin
         slope = dx != 0 ? rdiv(dy * aone, dx) : 0;
         pos  = rdiv(xa, one);
         pend = rdiv(xb, one);
         off  = pos * one - xa;
         acc  = ya * scl + rdiv(off * slope, one);
         while (pos < pend) begin
            pos++;
            acc += slope;
            plot(pos, rdiv(acc, aone), wd, ht, w.line_color, n);
         end
      end else begin
         inv  = rdiv(dx * aone * (dy < 0 ? -1 : 1), ady);
         pos  = rdiv(ya, one);
         pend = rdiv(yb, one);
         off  = pos * one - ya;
         acc  = xa * scl + rdiv(off * inv, one);
         s    = dy > 0 ? 1 : -1;
         while (s > 0 ? pos < pend : pos > pend) begin
            pos += s;
            acc += s * inv;
            plot(rdiv(acc, aone), pos, wd, ht, w.line_color, n);
         end
      end
      if (n > 0) pixel_q[pixel_q.size() - 1].last_pixel = 1'b1;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      width_reg  = 7'd64;
      height_reg = 7'd64;
   end

   assign pixels_pending = pixel_q.size();

   // handshakes seen at the falling edge complete at the next rising edge
   always @(negedge clock) begin
      rsp_word_type e;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_RASTER_WIDTH) width_reg = csr_wdata;
            else if (csr_index == CSR_RASTER_HEIGHT) height_reg = csr_wdata;
         end
         if (req_valid && !req_stall) rasterize(req_word);
         if (rsp_valid && !rsp_stall) begin
            if (pixel_q.size() == 0) begin
               report("unexpected pixel word", 32'(rsp_word.pixel_color), 32'd0);
            end else begin
               e = pixel_q.pop_front();
               if (rsp_word.pixel_x != e.pixel_x)
                  report("pixel_x", 32'(rsp_word.pixel_x), 32'(e.pixel_x));
               if (rsp_word.pixel_y != e.pixel_y)
                  report("pixel_y", 32'(rsp_word.pixel_y), 32'(e.pixel_y));
               if (rsp_word.pixel_color != e.pixel_color)
                  report("pixel_color", 32'(rsp_word.pixel_color), 32'(e.pixel_color));
               if (rsp_word.last_pixel != e.last_pixel)
                  report("last_pixel", 32'(rsp_word.last_pixel), 32'(e.last_pixel));
            end
         end
      end
   end

endmodule

[verif/dda_line_rasterizer_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dda_line_rasterizer_tb
// Drives directed and random line words through the rasterizer across several
// raster sizes, with random gaps and output stalls; a checker module predicts
// and compares every pixel word.
// ----------------------------------------------------------------------------
module dda_line_rasterizer_tb;
   import dda_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 1500;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_word_type         req_word = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_word_type         rsp_word;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_RASTER_WIDTH;
   logic [DIM_W-1:0]     csr_wdata = '0;
   int                   pixels_pending;
   int                   fail_count;
   int                   cycles = 0;
   int                   stall_pct = 0;

   always #2 clock = ~clock;

   dda_line_rasterizer i_dut (
      .clock, .reset, .req_valid, .req_stall, .req_word, .rsp_valid, .rsp_stall,
      .rsp_word, .csr_valid, .csr_ready, .csr_index, .csr_wdata
   );

   dda_line_checker i_checker (
      .clock, .reset, .req_valid, .req_stall, .req_word, .rsp_valid, .rsp_stall,
      .rsp_word, .csr_valid, .csr_ready, .csr_index, .csr_wdata,
      .pixels_pending, .fail_count
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      rsp_stall <= ($urandom_range(0, 9) < stall_pct);
      if (cycles > CYCLE_LIMIT) begin
         $display("dda_line_rasterizer regression: fail");
         $finish;
      end
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 19);
      if (r < 11) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_line(logic [11:0] xa, logic [11:0] ya, logic [11:0] xb,
                            logic [11:0] yb, logic [23:0] color);
      bit taken;
      int gap;
      req_valid <= 1'b1;
      req_word  <= '{start_x: xa, start_y: ya, end_x: xb, end_y: yb, line_color: color};
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      gap = gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pixels_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
      bit taken;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_raster(logic [DIM_W-1:0] wd, logic [DIM_W-1:0] ht);
      write_reg(CSR_RASTER_WIDTH, wd);
      write_reg(CSR_RASTER_HEIGHT, ht);
   endtask

   function automatic logic [11:0] near_coord();
      return 12'($signed($urandom_range(0, 1300)) - 200);
   endfunction

   task automatic random_lines(int count);
      int kind;
      logic [11:0] xa, ya, xb, yb;
      for (int i = 0; i < count; i++) begin
         kind = $urandom_range(0, 9);
         xa = near_coord(); ya = near_coord();
         if (kind < 6) begin
            xb = near_coord(); yb = near_coord();
         end else if (kind < 8) begin
            xb = xa + 12'($urandom_range(0, 64)) - 12'd32;
            yb = ya + 12'($urandom_range(0, 64)) - 12'd32;
         end else begin
            xa = 12'($urandom); ya = 12'($urandom);
            xb = 12'($urandom); yb = 12'($urandom);
         end
         send_line(xa, ya, xb, yb, 24'($urandom));
         if (i == count / 2 && count > 20) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (pixels_pending != 0) @(posedge clock);
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed lines on the reset raster
      send_line(12'd0, 12'd0, 12'd1008, 12'd1008, 24'hFFFFFF);
      send_line(12'd1008, 12'd0, 12'd0, 12'd1008, 24'h000000);
      send_line(12'd100, 12'd200, 12'd100, 12'd200, 24'hA5A5A5);
      send_line(12'd160, 12'd40, 12'd160, 12'd900, 24'h5A5A5A);
      send_line(12'd160, 12'd900, 12'd160, 12'd40, 24'h123456);
      send_line(12'd20, 12'd300, 12'd990, 12'd300, 24'h654321);
      send_line(12'd8, 12'd8, 12'd600, 12'd24, 24'h800001);
      send_line(12'd24, 12'd8, 12'd40, 12'd1000, 24'h7FFFFE);
      send_line(12'd500, 12'd1000, 12'd520, 12'd10, 24'h0F0F0F);
      send_line(12'h800, 12'h800, 12'h7FF, 12'h7FF, 24'hF0F0F0);
      send_line(12'h7FF, 12'h800, 12'h800, 12'h7FF, 24'h3C3C3C);
      send_line(12'h800, 12'h800, 12'h800, 12'h800, 24'hC3C3C3);
      send_line(12'h7FF, 12'h7FF, 12'h7FF, 12'h7FF, 24'h111111);
      send_line(-12'sd40, -12'sd40, 12'd300, 12'd300, 24'h222222);
      send_line(-12'sd8, 12'd8, 12'd8, -12'sd8, 24'h333333);
      send_line(12'd1020, 12'd10, 12'd1100, 12'd10, 24'h444444);
      send_line(12'd8, 12'd24, 12'd40, 12'd56, 24'h555555);
      send_line(-12'sd24, 12'd500, 12'd1100, 12'd520, 24'h666666);
      send_line(12'd300, -12'sd100, 12'd330, 12'd1100, 24'h777777);
      send_line(12'd7, 12'd9, 12'd9, 12'd7, 24'h888888);

      stall_pct = 3;
      random_lines(40);
      drain();
      set_raster(7'd1, 7'd1);
      stall_pct = 0;
      random_lines(25);
      drain();
      set_raster(7'd127, 7'd0);
      stall_pct = 7;
      random_lines(15);
      drain();
      set_raster(7'd37, 7'd20);
      stall_pct = 5;
      random_lines(45);
      drain();
      set_raster(7'd64, 7'd1);
      stall_pct = 2;
      random_lines(30);
      drain();
      set_raster(7'd100, 7'd127);
      stall_pct = 6;
      random_lines(55);
      drain();

      if (fail_count == 0) begin
         $display("dda_line_rasterizer regression: pass");
      end else begin
         $display("dda_line_rasterizer regression: fail");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/dda_pkg.sv
rtl/dda_front.sv
rtl/dda_queue.sv
rtl/dda_back.sv
rtl/dda_line_rasterizer.sv
rtl/dda_checker.sv
verif/dda_line_checker.sv
verif/dda_line_rasterizer_tb.sv
